FILE: rtl/eftd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eftd_pkg - shared types and constants of the edge-free tile detector
// Field widths, register indexes, reset values, geometry and queue entry types.
// ----------------------------------------------------------------------------
package eftd_pkg;

    // default limits for the top-level parameters
    localparam int DEF_MAX_WIDTH     = 2048;
    localparam int DEF_MAX_HEIGHT    = 2048;
    localparam int DEF_MAX_WINDOW    = 64;
    localparam int DEF_MAX_TILES     = 512;

    // field and register widths
    localparam int PIX_W   = 8;
    localparam int POS_W   = 11;
    localparam int WIN_W   = 7;
    localparam int HALF_W  = 6;
    localparam int TOP_W   = 11;
    localparam int TOP2_W  = 12;
    localparam int DIMR_W  = 12;
    localparam int DIM_W   = 14;
    localparam int XW      = 10;
    localparam int QW      = 9;
    localparam int CFG_DW  = 32;
    localparam int CFG_AW  = 4;

    // reciprocal table covers every half window a 7-bit register can give
    localparam int RECIP_N = 2 ** HALF_W;

    // border pixels left untouched on all four sides (top: after the top rows)
    localparam int BORDER  = 2;
    localparam int MIN_WIN = 4;

    // depth of the queue between the front and the back
    localparam int QDEPTH  = 4;

    typedef enum logic [1:0] {
        REG_WINDOW_SIZE  = 2'd0,
        REG_TOP_ROWS     = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } t_reg_idx;

    localparam logic [WIN_W-1:0]  RST_WINDOW_SIZE  = 7'd6;
    localparam logic [TOP_W-1:0]  RST_TOP_ROWS     = 11'd0;
    localparam logic [DIMR_W-1:0] RST_IMAGE_WIDTH  = 12'd480;
    localparam logic [DIMR_W-1:0] RST_IMAGE_HEIGHT = 12'd360;

    // effective geometry derived from the configuration registers
    typedef struct packed {
        logic [WIN_W-1:0]  w;
        logic [HALF_W-1:0] h;
        logic [TOP2_W-1:0] top2;
        logic [DIM_W-1:0]  wid;
        logic [DIM_W-1:0]  hgt;
    } t_geom;

    // one in-tile pixel handed from the front to the back
    typedef struct packed {
        logic [QW-1:0] tr;
        logic [QW-1:0] tc;
        logic          hit;
        logic          fresh;
        logic          last;
    } t_tile_op;

endpackage
`default_nettype wire

FILE: rtl/eftd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eftd_front - raster position tracking and tile classification
// Tracks the pixel position, divides the offsets by the window by reciprocal
// and correction, and pushes every pixel inside a whole tile to the queue.
// ----------------------------------------------------------------------------
module eftd_front #(
    parameter int MAX_TILES_PER_ROW = eftd_pkg::DEF_MAX_TILES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire eftd_pkg::t_geom            i_geom,
    input  wire logic                       i_valid,
    input  wire logic [eftd_pkg::PIX_W-1:0] i_pixel,
    input  wire logic                       i_frame_start,
    output logic                            o_stall,
    input  wire logic                       i_clr_busy,
    input  wire logic                       i_q_full,
    output logic                            o_q_push,
    output eftd_pkg::t_tile_op              o_q_data
);

    localparam int POS_W  = eftd_pkg::POS_W;
    localparam int DIM_W  = eftd_pkg::DIM_W;
    localparam int TOP2_W = eftd_pkg::TOP2_W;
    localparam int XW     = eftd_pkg::XW;
    localparam int QW     = eftd_pkg::QW;
    localparam int HALF_W = eftd_pkg::HALF_W;
    localparam int WIN_W  = eftd_pkg::WIN_W;

    // reciprocal table: floor(2^XW / h), exact quotient within one
    logic [XW-1:0] w_recip [eftd_pkg::RECIP_N];
    for (genvar Gi = 0; Gi < eftd_pkg::RECIP_N; Gi++) begin : g_recip
        if (Gi < 2) begin : g_zero
            assign w_recip[Gi] = '0;
        end else begin : g_val
            localparam int unsigned RecipVal = (1 << XW) / Gi;
            assign w_recip[Gi] = XW'(RecipVal);
        end
    end

    // position counters
    logic [POS_W-1:0] r_row, n_row;
    logic [POS_W-1:0] r_col, n_col;

    // stage registers
    logic             r_s1_valid, r_s2_valid, r_s3_valid;
    logic [POS_W-1:0] r_s1_rr, r_s1_cc, r_s2_rr, r_s2_cc, r_s3_rr, r_s3_cc;
    logic             r_s1_hit, r_s2_hit, r_s3_hit;
    logic [QW-1:0]    r_s2_q0_r, r_s2_q0_c;
    logic [QW-1:0]    r_s3_tr, r_s3_tc;
    logic [WIN_W-1:0] r_s3_ro, r_s3_co;

    logic             w_adv, w_acc, w_tile;
    logic [POS_W-1:0] w_row, w_col, w_rr, w_cc;
    logic             w_in_area;
    logic [DIM_W-1:0] w_col_inc, w_row_inc;
    logic [XW-1:0]    w_rcp;
    logic [2*XW-1:0]  w_prod_r, w_prod_c;
    logic [XW-1:0]    w_x_r, w_x_c, w_qh_r, w_qh_c, w_rem0_r, w_rem0_c, w_hx;
    logic [QW-1:0]    w_tr, w_tc;
    logic [HALF_W-1:0] w_rem_r, w_rem_c;
    logic [DIM_W-1:0] w_row_end, w_col_end;
    logic             w_row_ok, w_col_ok, w_tc_ok;
    logic [WIN_W-1:0] w_wm1;

    // stage 0: position of the incoming pixel and its area test
    always_comb begin
        w_row = i_frame_start ? '0 : r_row;
        w_col = i_frame_start ? '0 : r_col;
        w_in_area = (DIM_W'(w_row) < i_geom.hgt) && (DIM_W'(w_col) < i_geom.wid) &&
                    (TOP2_W'(w_row) >= i_geom.top2) &&
                    (w_col >= POS_W'(eftd_pkg::BORDER));
        w_rr = POS_W'(TOP2_W'(w_row) - i_geom.top2);
        w_cc = w_col - POS_W'(eftd_pkg::BORDER);
        w_col_inc = DIM_W'(w_col) + DIM_W'(1);
        w_row_inc = DIM_W'(w_row) + DIM_W'(1);
        if (w_col_inc >= i_geom.wid) begin
            n_col = '0;
            n_row = (w_row_inc >= i_geom.hgt) ? '0 : POS_W'(w_row_inc);
        end else begin
            n_col = POS_W'(w_col_inc);
            n_row = w_row;
        end
    end

    // stage 1: quotient estimate by reciprocal
    always_comb begin
        w_rcp    = w_recip[i_geom.h];
        w_prod_r = r_s1_rr[POS_W-1:1] * w_rcp;
        w_prod_c = r_s1_cc[POS_W-1:1] * w_rcp;
    end

    // stage 2: remainder and one correction step
    always_comb begin
        w_hx     = XW'(i_geom.h);
        w_x_r    = r_s2_rr[POS_W-1:1];
        w_x_c    = r_s2_cc[POS_W-1:1];
        w_qh_r   = XW'(XW'(r_s2_q0_r) * w_hx);
        w_qh_c   = XW'(XW'(r_s2_q0_c) * w_hx);
        w_rem0_r = w_x_r - w_qh_r;
        w_rem0_c = w_x_c - w_qh_c;
        if (w_rem0_r >= w_hx) begin
            w_tr    = r_s2_q0_r + QW'(1);
            w_rem_r = HALF_W'(w_rem0_r - w_hx);
        end else begin
            w_tr    = r_s2_q0_r;
            w_rem_r = HALF_W'(w_rem0_r);
        end
        if (w_rem0_c >= w_hx) begin
            w_tc    = r_s2_q0_c + QW'(1);
            w_rem_c = HALF_W'(w_rem0_c - w_hx);
        end else begin
            w_tc    = r_s2_q0_c;
            w_rem_c = HALF_W'(w_rem0_c);
        end
    end

    // stage 3: whole-tile test and tile corner flags
    always_comb begin
        w_row_end = DIM_W'(r_s3_rr) - DIM_W'(r_s3_ro) + DIM_W'(i_geom.w) +
                    DIM_W'(i_geom.top2) + DIM_W'(eftd_pkg::BORDER);
        w_col_end = DIM_W'(r_s3_cc) - DIM_W'(r_s3_co) + DIM_W'(i_geom.w) +
                    DIM_W'(2 * eftd_pkg::BORDER);
        w_row_ok  = w_row_end <= i_geom.hgt;
        w_col_ok  = w_col_end <= i_geom.wid;
        w_tc_ok   = 32'(r_s3_tc) < 32'(MAX_TILES_PER_ROW);
        w_tile    = r_s3_valid && w_row_ok && w_col_ok && w_tc_ok;
        w_wm1     = i_geom.w - WIN_W'(1);
        o_q_data.tr    = r_s3_tr;
        o_q_data.tc    = r_s3_tc;
        o_q_data.hit   = r_s3_hit;
        o_q_data.fresh = (r_s3_ro == '0) && (r_s3_co == '0);
        o_q_data.last  = (r_s3_ro == w_wm1) && (r_s3_co == w_wm1);
    end

    assign w_adv    = !(w_tile && i_q_full);
    assign o_stall  = i_clr_busy || !w_adv;
    assign w_acc    = i_valid && !o_stall;
    assign o_q_push = w_tile && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (w_adv) begin
                r_s1_valid <= w_acc && w_in_area;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_rr   <= w_rr;
            r_s1_cc   <= w_cc;
            r_s1_hit  <= i_pixel != '0;
            r_s2_rr   <= r_s1_rr;
            r_s2_cc   <= r_s1_cc;
            r_s2_hit  <= r_s1_hit;
            r_s2_q0_r <= w_prod_r[XW+QW-1:XW];
            r_s2_q0_c <= w_prod_c[XW+QW-1:XW];
            r_s3_rr   <= r_s2_rr;
            r_s3_cc   <= r_s2_cc;
            r_s3_hit  <= r_s2_hit;
            r_s3_tr   <= w_tr;
            r_s3_tc   <= w_tc;
            r_s3_ro   <= {w_rem_r, r_s2_rr[0]};
            r_s3_co   <= {w_rem_c, r_s2_cc[0]};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/eftd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eftd_queue - short queue of tile operations between front and back
// Register-based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module eftd_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire eftd_pkg::t_tile_op i_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output eftd_pkg::t_tile_op      o_data
);

    localparam int DEPTH = eftd_pkg::QDEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    eftd_pkg::t_tile_op r_q [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/eftd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eftd_back - per-tile-column edge flags and verdict output
// Read-modify-write of the flag memory with forwarding, clearing pass after
// reset, and the output register toward the consumer.
// ----------------------------------------------------------------------------
module eftd_back #(
    parameter int MAX_TILES_PER_ROW = eftd_pkg::DEF_MAX_TILES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_q_valid,
    input  wire eftd_pkg::t_tile_op      i_q_data,
    output logic                         o_q_pop,
    output logic                         o_clr_busy,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [eftd_pkg::QW-1:0]      o_tile_row,
    output logic [eftd_pkg::QW-1:0]      o_tile_col,
    output logic                         o_edge_free
);

    localparam int DEPTH = MAX_TILES_PER_ROW;
    localparam int AW    = $clog2(DEPTH);

    logic               r_mem [DEPTH];
    logic               r_rdata;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;
    logic               r_b_valid;
    eftd_pkg::t_tile_op r_b_op;
    logic               r_b_fsel, r_b_fval;
    logic               r_out_valid;

    logic          w_out_ready, w_b_fire, w_load, w_old, w_flag;
    logic [AW-1:0] w_q_addr, w_b_addr;

    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_b_fire    = r_b_valid && (!r_b_op.last || w_out_ready);
    assign w_load      = i_q_valid && (!r_b_valid || w_b_fire) && !r_clr_busy;
    assign w_q_addr    = AW'(i_q_data.tc);
    assign w_b_addr    = AW'(r_b_op.tc);
    assign w_old       = r_b_fsel ? r_b_fval : r_rdata;
    assign w_flag      = r_b_op.fresh ? r_b_op.hit : (w_old | r_b_op.hit);
    assign o_q_pop     = w_load;
    assign o_clr_busy  = r_clr_busy;
    assign o_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (w_load) begin
                r_b_valid <= 1'b1;
            end else if (w_b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_fire && r_b_op.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // flag memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (w_b_fire) begin
            r_mem[w_b_addr] <= w_flag;
        end
        if (w_load) begin
            r_rdata <= r_mem[w_q_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_b_op   <= i_q_data;
            r_b_fsel <= w_b_fire && (w_b_addr == w_q_addr);
            r_b_fval <= w_flag;
        end
        if (w_b_fire && r_b_op.last) begin
            o_tile_row  <= r_b_op.tr;
            o_tile_col  <= r_b_op.tc;
            o_edge_free <= !w_flag;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/edge_free_tile_detector_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edge_free_tile_detector_core - edge-free tile verdicts over a binary image
// Takes an edge image in raster order and reports, per whole tile, whether
// the tile held no edge pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one pixel per transfer, raster order,
//   i_frame_start on the first pixel of a frame. Up to one transfer a cycle.
//   Output channel (o_valid / i_stall): one verdict per finished tile, with
//   its tile row and tile column, issued on the tile's last pixel.
//   Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12
//   (window_size, top_rows, image_width, image_height); write only while
//   no pixel is in flight. Reads return the raw register values.
//   Path: the tile's last pixel passes front stages 1 to 3, the queue, the
//   back stage and the output register. Throughput: one pixel per cycle
//   while o_stall is low, held by the forwarded flag read-modify-write.
//   Reset: position counters return to row 0, column 0; the flag memory is
//   then cleared one entry a cycle, all MAX_TILES_PER_ROW entries (512 by
//   default), with o_stall held high; config writes are taken throughout.
//   Receiver stall: the output register holds its verdict, the back stage
//   and the four-entry queue fill, then o_stall rises until room returns.
// ----------------------------------------------------------------------------
module edge_free_tile_detector_core #(
    parameter int MAX_WIDTH         = eftd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT        = eftd_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW        = eftd_pkg::DEF_MAX_WINDOW,
    parameter int MAX_TILES_PER_ROW = eftd_pkg::DEF_MAX_TILES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // pixel input
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [eftd_pkg::PIX_W-1:0]  i_pixel,
    input  wire logic                        i_frame_start,
    // verdict output
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [eftd_pkg::QW-1:0]          o_tile_row,
    output logic [eftd_pkg::QW-1:0]          o_tile_col,
    output logic                             o_edge_free,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [eftd_pkg::CFG_AW-1:0] paddr,
    input  wire logic [eftd_pkg::CFG_DW-1:0] pwdata,
    output logic [eftd_pkg::CFG_DW-1:0]      prdata,
    output logic                             pready
);

    localparam int WIN_W  = eftd_pkg::WIN_W;
    localparam int TOP_W  = eftd_pkg::TOP_W;
    localparam int TOP2_W = eftd_pkg::TOP2_W;
    localparam int DIMR_W = eftd_pkg::DIMR_W;
    localparam int DIM_W  = eftd_pkg::DIM_W;
    localparam int CFG_DW = eftd_pkg::CFG_DW;

    // largest even window the register can reach under MAX_WINDOW
    localparam int              WIN_LIM = (MAX_WINDOW > 126) ? 126 : MAX_WINDOW;
    localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(WIN_LIM & ~1);
    localparam logic [DIM_W-1:0] WID_CAP = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HGT_CAP = DIM_W'(MAX_HEIGHT);

    logic [WIN_W-1:0]  r_window_size;
    logic [TOP_W-1:0]  r_top_rows;
    logic [DIMR_W-1:0] r_image_width;
    logic [DIMR_W-1:0] r_image_height;

    logic              w_cfg_wr;
    logic [WIN_W-1:0]  w_win;
    eftd_pkg::t_geom   w_geom;

    logic               w_clr_busy, w_q_full, w_q_push, w_q_pop, w_q_valid;
    eftd_pkg::t_tile_op w_q_in, w_q_out;

    // --- configuration registers -------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size  <= eftd_pkg::RST_WINDOW_SIZE;
            r_top_rows     <= eftd_pkg::RST_TOP_ROWS;
            r_image_width  <= eftd_pkg::RST_IMAGE_WIDTH;
            r_image_height <= eftd_pkg::RST_IMAGE_HEIGHT;
        end else if (w_cfg_wr) begin
            case (eftd_pkg::t_reg_idx'(paddr[3:2]))
                eftd_pkg::REG_WINDOW_SIZE:  r_window_size  <= pwdata[WIN_W-1:0];
                eftd_pkg::REG_TOP_ROWS:     r_top_rows     <= pwdata[TOP_W-1:0];
                eftd_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[DIMR_W-1:0];
                eftd_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[DIMR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (eftd_pkg::t_reg_idx'(paddr[3:2]))
            eftd_pkg::REG_WINDOW_SIZE:  prdata = CFG_DW'(r_window_size);
            eftd_pkg::REG_TOP_ROWS:     prdata = CFG_DW'(r_top_rows);
            eftd_pkg::REG_IMAGE_WIDTH:  prdata = CFG_DW'(r_image_width);
            eftd_pkg::REG_IMAGE_HEIGHT: prdata = CFG_DW'(r_image_height);
            default:                    prdata = '0;
        endcase
    end

    // --- effective geometry ------------------------------------------------
    // Drop the odd bit of the window, raise it to the minimum, cap it;
    // clamp the image size to 1..MAX.
    always_comb begin
        w_win = {r_window_size[WIN_W-1:1], 1'b0};
        if (w_win < WIN_W'(eftd_pkg::MIN_WIN)) begin
            w_win = WIN_W'(eftd_pkg::MIN_WIN);
        end
        if (w_win > WIN_CAP) begin
            w_win = WIN_CAP;
        end
        w_geom.w    = w_win;
        w_geom.h    = w_win[WIN_W-1:1];
        w_geom.top2 = TOP2_W'(r_top_rows) + TOP2_W'(eftd_pkg::BORDER);
        if (r_image_width == '0) begin
            w_geom.wid = DIM_W'(1);
        end else if (DIM_W'(r_image_width) > WID_CAP) begin
            w_geom.wid = WID_CAP;
        end else begin
            w_geom.wid = DIM_W'(r_image_width);
        end
        if (r_image_height == '0) begin
            w_geom.hgt = DIM_W'(1);
        end else if (DIM_W'(r_image_height) > HGT_CAP) begin
            w_geom.hgt = HGT_CAP;
        end else begin
            w_geom.hgt = DIM_W'(r_image_height);
        end
    end

    // --- front: positions, tile division, whole-tile test ------------------
    eftd_front #(
        .MAX_TILES_PER_ROW (MAX_TILES_PER_ROW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (w_geom),
        .i_valid       (i_valid),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_stall       (o_stall),
        .i_clr_busy    (w_clr_busy),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_data      (w_q_in)
    );

    // --- queue: lets the front run on while the back holds a verdict -------
    eftd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    // --- back: flag memory update and verdict register ---------------------
    eftd_back #(
        .MAX_TILES_PER_ROW (MAX_TILES_PER_ROW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_out),
        .o_q_pop     (w_q_pop),
        .o_clr_busy  (w_clr_busy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tile_row  (o_tile_row),
        .o_tile_col  (o_tile_col),
        .o_edge_free (o_edge_free)
    );

endmodule
`default_nettype wire
